// ===== rtl/core/iprtlpm_pkg.sv =====
// Shared constants, types and helper functions of the IPv4 longest-prefix-match route table.
package iprtlpm_pkg;

    localparam int TABLE_DEPTH = 16;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam logic [5:0] MAX_LEN = 6'd32;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] addr;
        logic [5:0]  len;
        logic [7:0]  ifx;
        logic [31:0] nh;
        logic        hit;
    } token_t;

    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0)
        begin
            m = 32'h0;
        end
        else
        begin
            m = 32'hffff_ffff << (MAX_LEN - len);
        end
        return m;
    endfunction

    function automatic logic [5:0] clamp_len(input logic [5:0] len);
        return (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

endpackage

// ===== rtl/core/ipv4_route_table_lpm_top.sv =====
// Top level of the IPv4 longest-prefix-match route table built as a chain of slot cells.
//
// Each input item is one command: insert a route, look up a destination address, or
// delete a route. Every item produces exactly one result item on the output channel.
// Both channels use valid and ready; an item moves when both are high at a clock edge.
// The table is a chain of TABLE_DEPTH cells, each holding one route slot. An item walks
// down the chain one cell per cycle while the output is not stalled, and each cell updates
// the slot or the item's running result as it passes, so a later item always sees the
// slots as the earlier one left them. The first cell loads the item at the accepting edge,
// each further cell registers it in turn, and the output register then holds the result.
// Throughput is one item per cycle while no result is held waiting, since several items
// travel down the chain at once, one in each cell stage.
// Reset empties the table and the chain; no clearing pass is needed, so in_ready is high
// in the first cycle after reset. When the receiver holds out_ready low while a result is
// waiting, the whole chain stops and in_ready falls until that result is taken.
module ipv4_route_table_lpm_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] address,
    input  logic [5:0]  prefix_length,
    input  logic [7:0]  interface_index,
    input  logic [31:0] next_hop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  out_interface,
    output logic [31:0] out_next_hop,
    output logic [5:0]  matched_length
);

    logic                advance;
    logic                chain_valid [0:iprtlpm_pkg::TABLE_DEPTH];
    iprtlpm_pkg::token_t chain_tok   [0:iprtlpm_pkg::TABLE_DEPTH];
    iprtlpm_pkg::token_t last_tok;
    logic [5:0]          len_c;
    logic                out_valid_reg;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic [7:0]          out_interface_reg;
    logic [31:0]         out_next_hop_reg;
    logic [5:0]          matched_length_reg;
    logic                is_lookup;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    assign len_c = iprtlpm_pkg::clamp_len(prefix_length);

    always_comb
    begin
        chain_valid[0]      = in_valid;
        chain_tok[0].action = action;
        chain_tok[0].hit    = 1'b0;
        if (action == iprtlpm_pkg::ACT_LOOKUP)
        begin
            chain_tok[0].addr = address;
            chain_tok[0].len  = 6'd0;
            chain_tok[0].ifx  = 8'd0;
            chain_tok[0].nh   = 32'h0;
        end
        else
        begin
            chain_tok[0].addr = address & iprtlpm_pkg::len_mask(len_c);
            chain_tok[0].len  = len_c;
            chain_tok[0].ifx  = interface_index;
            chain_tok[0].nh   = next_hop;
        end
    end

    genvar g;
    generate
        for (g = 0; g < iprtlpm_pkg::TABLE_DEPTH; g++)
        begin : g_cell
            iprtlpm_cell u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .advance       (advance),
                .tok_in_valid  (chain_valid[g]),
                .tok_in        (chain_tok[g]),
                .tok_out_valid (chain_valid[g+1]),
                .tok_out       (chain_tok[g+1])
            );
        end
    endgenerate

    assign last_tok  = chain_tok[iprtlpm_pkg::TABLE_DEPTH];
    assign is_lookup = (last_tok.action == iprtlpm_pkg::ACT_LOOKUP);

    always_comb
    begin
        unique case (last_tok.action)
            iprtlpm_pkg::ACT_INSERT:
                status_next = last_tok.hit ? iprtlpm_pkg::ST_OK : iprtlpm_pkg::ST_FULL;
            iprtlpm_pkg::ACT_LOOKUP,
            iprtlpm_pkg::ACT_DELETE:
                status_next = last_tok.hit ? iprtlpm_pkg::ST_OK : iprtlpm_pkg::ST_MISS;
            default:
                status_next = iprtlpm_pkg::ST_MISS;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_valid[iprtlpm_pkg::TABLE_DEPTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && chain_valid[iprtlpm_pkg::TABLE_DEPTH])
        begin
            status_reg         <= status_next;
            out_interface_reg  <= is_lookup ? last_tok.ifx : 8'd0;
            out_next_hop_reg   <= is_lookup ? last_tok.nh : 32'h0;
            matched_length_reg <= is_lookup ? last_tok.len : 6'd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign out_interface  = out_interface_reg;
    assign out_next_hop   = out_next_hop_reg;
    assign matched_length = matched_length_reg;

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != iprtlpm_pkg::ST_OK) |->
        (out_interface == 8'd0 && out_next_hop == 32'h0 && matched_length == 6'd0))
        else $error("A failed command returned nonzero route fields.");

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (matched_length <= iprtlpm_pkg::MAX_LEN))
        else $error("Matched length exceeds the address width.");

    a_stall_holds_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> (chain_valid[iprtlpm_pkg::TABLE_DEPTH] ==
                      $past(chain_valid[iprtlpm_pkg::TABLE_DEPTH])))
        else $error("The cell chain moved while the output was stalled.");

endmodule

// ===== rtl/core/iprtlpm_cell.sv =====
// One slot of the route table and the stage that carries a command item past it.
module iprtlpm_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 tok_in_valid,
    input  iprtlpm_pkg::token_t  tok_in,
    output logic                 tok_out_valid,
    output iprtlpm_pkg::token_t  tok_out
);

    logic                entry_valid_reg;
    logic                entry_valid_next;
    logic [31:0]         entry_prefix_reg;
    logic [5:0]          entry_length_reg;
    logic [7:0]          entry_interface_reg;
    logic [31:0]         entry_next_hop_reg;
    logic                entry_write;
    logic                tok_valid_reg;
    iprtlpm_pkg::token_t tok_reg;
    iprtlpm_pkg::token_t tok_next;
    logic                lookup_match;
    logic                delete_match;

    assign lookup_match = entry_valid_reg &&
        (((tok_in.addr ^ entry_prefix_reg) & iprtlpm_pkg::len_mask(entry_length_reg)) == 32'h0);
    assign delete_match = entry_valid_reg && (entry_length_reg == tok_in.len) &&
        (entry_prefix_reg == tok_in.addr);

    always_comb
    begin
        tok_next         = tok_in;
        entry_valid_next = entry_valid_reg;
        entry_write      = 1'b0;
        if (tok_in_valid)
        begin
            unique case (tok_in.action)
                iprtlpm_pkg::ACT_INSERT:
                begin
                    if (!tok_in.hit && !entry_valid_reg)
                    begin
                        entry_write      = 1'b1;
                        entry_valid_next = 1'b1;
                        tok_next.hit     = 1'b1;
                    end
                end
                iprtlpm_pkg::ACT_LOOKUP:
                begin
                    if (lookup_match && (!tok_in.hit || entry_length_reg > tok_in.len))
                    begin
                        tok_next.hit = 1'b1;
                        tok_next.len = entry_length_reg;
                        tok_next.ifx = entry_interface_reg;
                        tok_next.nh  = entry_next_hop_reg;
                    end
                end
                iprtlpm_pkg::ACT_DELETE:
                begin
                    if (delete_match)
                    begin
                        entry_valid_next = 1'b0;
                        tok_next.hit     = 1'b1;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            tok_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            entry_valid_reg <= entry_valid_next;
            tok_valid_reg   <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg <= tok_next;
            if (entry_write)
            begin
                entry_prefix_reg    <= tok_in.addr;
                entry_length_reg    <= tok_in.len;
                entry_interface_reg <= tok_in.ifx;
                entry_next_hop_reg  <= tok_in.nh;
            end
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

    a_insert_fills_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tok_in_valid && tok_in.action == iprtlpm_pkg::ACT_INSERT &&
         !tok_in.hit && !entry_valid_reg) |=> (entry_valid_reg && tok_reg.hit))
        else $error("Insert item passed a free slot without storing its route.");

    a_delete_clears_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tok_in_valid && tok_in.action == iprtlpm_pkg::ACT_DELETE &&
         delete_match) |=> !entry_valid_reg)
        else $error("Delete item left a matching route in its slot.");

    a_hit_is_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tok_in_valid && tok_in.hit) |=> tok_reg.hit)
        else $error("Item lost its hit flag while passing a slot.");

    a_lookup_len_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tok_in_valid && tok_in.action == iprtlpm_pkg::ACT_LOOKUP)
        |=> (tok_reg.len >= $past(tok_in.len)))
        else $error("Lookup item replaced its best route with a shorter prefix.");

endmodule

// ===== sim/ipv4_route_table_lpm_checker.sv =====
// Checker that predicts the route table's results and compares them with what the block returns.
module ipv4_route_table_lpm_checker
    import iprtlpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] address,
    input  logic [5:0]  prefix_length,
    input  logic [7:0]  interface_index,
    input  logic [31:0] next_hop,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [7:0]  out_interface,
    input  logic [31:0] out_next_hop,
    input  logic [5:0]  matched_length,
    output int          pending,
    output int          failures
);

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  ifx;
        logic [31:0] nh;
        logic [5:0]  len;
    } route_result_t;

    logic        slot_used [TABLE_DEPTH];
    logic [31:0] slot_prefix [TABLE_DEPTH];
    logic [5:0]  slot_len [TABLE_DEPTH];
    logic [7:0]  slot_ifx [TABLE_DEPTH];
    logic [31:0] slot_nh [TABLE_DEPTH];

    route_result_t expected_routes [$];
    int            pending_count = 0;
    int            mismatches = 0;

    assign pending  = pending_count;
    assign failures = mismatches;

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        return ~(32'hffff_ffff >> len);
    endfunction

    // Applies one command to the shadow table and returns the result it should produce.
    function automatic route_result_t execute_command(
        input logic [1:0]  act,
        input logic [31:0] addr,
        input logic [5:0]  raw_len,
        input logic [7:0]  ifx,
        input logic [31:0] nh
    );
        route_result_t res;
        logic [5:0]    len;
        logic [31:0]   mask;
        logic          found;
        int            i;
        res = '0;
        res.status = ST_MISS;
        len = (raw_len > 6'd32) ? 6'd32 : raw_len;
        mask = prefix_mask(len);
        found = 1'b0;
        case (act)
            ACT_INSERT:
            begin
                res.status = ST_FULL;
                for (i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (!found && !slot_used[i])
                    begin
                        found = 1'b1;
                        slot_used[i] = 1'b1;
                        slot_prefix[i] = addr & mask;
                        slot_len[i] = len;
                        slot_ifx[i] = ifx;
                        slot_nh[i] = nh;
                        res.status = ST_OK;
                    end
                end
            end
            ACT_LOOKUP:
            begin
                for (i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (slot_used[i] && ((addr ^ slot_prefix[i]) & prefix_mask(slot_len[i])) == 0
                        && (!found || slot_len[i] > res.len))
                    begin
                        found = 1'b1;
                        res.len = slot_len[i];
                        res.ifx = slot_ifx[i];
                        res.nh = slot_nh[i];
                    end
                end
                res.status = found ? ST_OK : ST_MISS;
            end
            ACT_DELETE:
            begin
                for (i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (slot_used[i] && slot_len[i] == len && ((slot_prefix[i] ^ addr) & mask) == 0)
                    begin
                        slot_used[i] = 1'b0;
                        res.status = ST_OK;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        route_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                slot_used[i] = 1'b0;
            end
            expected_routes.delete();
            pending_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_routes.push_back(execute_command(action, address, prefix_length,
                                                          interface_index, next_hop));
            end
            if (out_valid && out_ready)
            begin
                if (expected_routes.size() == 0)
                begin
                    $display("%0t: result with no item waiting, expected none actual %h",
                             $time, {status, out_interface, out_next_hop, matched_length});
                    mismatches++;
                end
                else
                begin
                    want = expected_routes.pop_front();
                    mismatches += field_mismatch("status", want.status, status);
                    mismatches += field_mismatch("out_interface", want.ifx, out_interface);
                    mismatches += field_mismatch("out_next_hop", want.nh, out_next_hop);
                    mismatches += field_mismatch("matched_length", want.len, matched_length);
                end
            end
            pending_count <= expected_routes.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench top that drives commands into the IPv4 route table and reports the verdict.
module testbench;
    import iprtlpm_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
    localparam int RANDOM_ITEMS = 400;

    typedef struct {
        logic [31:0] addr;
        logic [5:0]  len;
    } route_key_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [1:0]  action = '0;
    logic [31:0] address = '0;
    logic [5:0]  prefix_length = '0;
    logic [7:0]  interface_index = '0;
    logic [31:0] next_hop = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  status;
    logic [7:0]  out_interface;
    logic [31:0] out_next_hop;
    logic [5:0]  matched_length;

    int          pending;
    int          failures;
    int          send_idle = 0;
    int          recv_idle = 0;
    route_key_t  stored_routes [$];
    logic [31:0] networks [4];

    ipv4_route_table_lpm_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .address         (address),
        .prefix_length   (prefix_length),
        .interface_index (interface_index),
        .next_hop        (next_hop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .out_interface   (out_interface),
        .out_next_hop    (out_next_hop),
        .matched_length  (matched_length)
    );

    ipv4_route_table_lpm_checker route_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .address         (address),
        .prefix_length   (prefix_length),
        .interface_index (interface_index),
        .next_hop        (next_hop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .out_interface   (out_interface),
        .out_next_hop    (out_next_hop),
        .matched_length  (matched_length),
        .pending         (pending),
        .failures        (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_command(input logic [1:0] act, input logic [31:0] addr,
                                input logic [5:0] len, input logic [7:0] ifx,
                                input logic [31:0] nh);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
            begin
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        action <= act;
        address <= addr;
        prefix_length <= len;
        interface_index <= ifx;
        next_hop <= nh;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int          mode;
        int          pick;
        int          ins_pct;
        int          del_pct;
        int          k;
        logic [1:0]  act;
        logic [31:0] addr;
        logic [5:0]  len;
        route_key_t  key;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        send_idle = 31;
        recv_idle = 88;

        send_command(ACT_LOOKUP, 32'hffff_ffff, 6'd0, 8'd0, 32'd0);
        send_command(ACT_DELETE, 32'h0000_0000, 6'd0, 8'hff, 32'hffff_ffff);
        send_command(ACT_UNUSED, 32'hffff_ffff, 6'd63, 8'hff, 32'hffff_ffff);
        send_command(ACT_INSERT, 32'h0a00_0000, 6'd8, 8'd1, 32'hc0a8_0001);
        send_command(ACT_INSERT, 32'h0a01_ffff, 6'd16, 8'd2, 32'hc0a8_0002);
        send_command(ACT_INSERT, 32'h0a01_0203, 6'd63, 8'd3, 32'hc0a8_0003);
        send_command(ACT_INSERT, 32'hffff_ffff, 6'd0, 8'hff, 32'hffff_ffff);
        send_command(ACT_INSERT, 32'h0a00_0000, 6'd8, 8'd5, 32'h0000_0000);
        send_command(ACT_INSERT, 32'h0000_0000, 6'd32, 8'd0, 32'h0000_0000);
        send_command(ACT_LOOKUP, 32'h0a01_0203, 6'd0, 8'd0, 32'd0);
        send_command(ACT_LOOKUP, 32'h0a01_0909, 6'd0, 8'd0, 32'd0);
        send_command(ACT_LOOKUP, 32'h0ac8_0000, 6'd0, 8'd0, 32'd0);
        send_command(ACT_LOOKUP, 32'hc0a8_0001, 6'd0, 8'd0, 32'd0);
        send_command(ACT_LOOKUP, 32'h0000_0000, 6'd0, 8'd0, 32'd0);
        send_command(ACT_DELETE, 32'h0aff_0000, 6'd8, 8'd0, 32'd0);
        send_command(ACT_LOOKUP, 32'h0ac8_0000, 6'd0, 8'd0, 32'd0);
        send_command(ACT_DELETE, 32'h0a01_0203, 6'd40, 8'd0, 32'd0);
        send_command(ACT_LOOKUP, 32'h0a01_0203, 6'd0, 8'd0, 32'd0);
        send_command(ACT_DELETE, 32'h1234_5678, 6'd0, 8'd0, 32'd0);
        send_command(ACT_LOOKUP, 32'h1234_5678, 6'd0, 8'd0, 32'd0);
        send_command(ACT_DELETE, 32'h0a01_0000, 6'd16, 8'd0, 32'd0);
        send_command(ACT_DELETE, 32'h0000_0000, 6'd32, 8'd0, 32'd0);
        wait_for_results();

        for (int i = 0; i < 4; i++)
        begin
            networks[i] = $urandom();
        end
        mode = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle = 88;
                recv_idle = 31;
            end
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (n == RANDOM_ITEMS / 2)
            begin
                wait_for_results();
            end
            // Insert-heavy stretches fill the table; delete-heavy stretches drain it.
            if (n % 40 == 0)
            begin
                mode = $urandom_range(2);
            end
            ins_pct = (mode == 1) ? 70 : (mode == 2) ? 15 : 35;
            del_pct = (mode == 1) ? 5 : (mode == 2) ? 50 : 17;
            pick = $urandom_range(99);
            k = $urandom_range(3);
            len = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 33)) : 6'($urandom_range(32));
            addr = networks[k] ^ ($urandom() >> $urandom_range(32));
            if ($urandom_range(9) == 0)
            begin
                addr = $urandom();
            end
            if (pick < 3)
            begin
                act = ACT_UNUSED;
            end
            else if (pick < 3 + ins_pct)
            begin
                act = ACT_INSERT;
            end
            else if (pick < 3 + ins_pct + del_pct)
            begin
                act = ACT_DELETE;
            end
            else
            begin
                act = ACT_LOOKUP;
            end
            if (act == ACT_DELETE && stored_routes.size() > 0 && $urandom_range(9) < 7)
            begin
                key = stored_routes[$urandom_range(stored_routes.size() - 1)];
                addr = key.addr ^ ($urandom() & (32'hffff_ffff >> key.len));
                len = key.len;
                if (len == 6'd32 && $urandom_range(1) == 1)
                begin
                    len = 6'($urandom_range(63, 33));
                end
            end
            if (act == ACT_INSERT)
            begin
                key.addr = addr;
                key.len = (len > 6'd32) ? 6'd32 : len;
                stored_routes.push_back(key);
                if (stored_routes.size() > 24)
                begin
                    void'(stored_routes.pop_front());
                end
            end
            send_command(act, addr, len, 8'($urandom_range(255)), $urandom());
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
